// File: hw/rtl/car_pkg.sv
// Package for the contiguous run allocator: table geometry, field widths,
// status and opcode codes, controller state type. No dependencies.
`timescale 1ns / 1ps

package car_pkg;

   localparam int TABLE_ENTRIES = 8192;
   localparam int WORD_W = (TABLE_ENTRIES >= 128) ? 32 : TABLE_ENTRIES / 4;
   localparam int BIT_W = $clog2(WORD_W);
   localparam int WORDS = TABLE_ENTRIES / WORD_W;
   localparam int ADDR_W = $clog2(WORDS);
   localparam int IDX_W = ADDR_W + BIT_W;

   localparam int CNT_W = 14;
   localparam int SEL_W = 16;
   localparam int ENTRY_W = 13;
   localparam int SEL_SHIFT = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [SEL_SHIFT-1:0] SEL_LOW_BITS = 3'b111;
   localparam logic [ENTRY_W-1:0] FIRST_FREE_RESET = 13'd17;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK = 2'd0;
   localparam status_type STATUS_NO_ROOM = 2'd1;
   localparam status_type STATUS_WAS_FREE = 2'd2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE = 1'b1;

   localparam logic CSR_REG_FIRST_FREE = 1'b0;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SCAN = 6'b000010,
      ST_MARK = 6'b000100,
      ST_FRD  = 6'b001000,
      ST_FCHK = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

endpackage

// File: hw/rtl/car_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module car_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/contiguous_run_allocator.sv
// Contiguous run allocator: first-fit bitmap over the table, one word per RAM entry.
// Uses car_pkg and car_ram. Free: FRD reads the map word, FCHK clears the bit, DONE queues the result.
// Allocate: SCAN then MARK, each reading one RAM word per cycle, then DONE; one transaction in
// flight, next accepted once the result is queued.
// Reset: map reads as all free at once (per-word valid flags), first_free_entry = 17.
`timescale 1ns / 1ps

module contiguous_run_allocator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_opcode,
   input  logic [car_pkg::CNT_W-1:0]        req_run_length,
   input  logic [car_pkg::SEL_W-1:0]        req_selector_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic [car_pkg::SEL_W-1:0]        rsp_selector_out,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [car_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [car_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [car_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   localparam int WORD_W = car_pkg::WORD_W;
   localparam int BIT_W = car_pkg::BIT_W;
   localparam int ADDR_W = car_pkg::ADDR_W;
   localparam int IDX_W = car_pkg::IDX_W;
   localparam int CNT_W = car_pkg::CNT_W;
   localparam int SEL_W = car_pkg::SEL_W;
   localparam int ENTRY_W = car_pkg::ENTRY_W;
   localparam int WORDS = car_pkg::WORDS;
   localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};
   localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORDS - 1);

   // bit j set where entries j-want+1..j of the word are all free
   function automatic logic [WORD_W-1:0] window_free(input logic [WORD_W-1:0] f,
                                                     input logic [CNT_W-1:0] want);
      logic [WORD_W-1:0] pw [BIT_W+1];
      logic [WORD_W-1:0] acc;
      logic [CNT_W-1:0]  sh;
      pw[0] = f;
      for (int b = 1; b <= BIT_W; b++) begin
         pw[b] = pw[b-1] & (pw[b-1] << (1 << (b - 1)));
      end
      acc = ONES;
      sh = '0;
      for (int b = 0; b < BIT_W; b++) begin
         if (want[b]) begin
            acc = acc & (pw[b] << sh);
            sh = sh | (CNT_W'(1) << b);
         end
      end
      if (want == CNT_W'(WORD_W)) begin
         acc = pw[BIT_W];
      end else if (want > CNT_W'(WORD_W)) begin
         acc = '0;
      end
      return acc;
   endfunction

   // bit j set where entries 0..j of the word are all free
   function automatic logic [WORD_W-1:0] prefix_free(input logic [WORD_W-1:0] f);
      logic [WORD_W-1:0] s;
      s = ~f;
      for (int k = 0; k < BIT_W; k++) begin
         s = s | (s << (1 << k));
      end
      return ~s;
   endfunction

   function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

   // free entries at the top of the word, word not all free
   function automatic logic [BIT_W:0] top_free(input logic [WORD_W-1:0] f);
      logic [BIT_W:0] cnt;
      cnt = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (!f[i]) begin
            cnt = (BIT_W + 1)'(WORD_W - 1 - i);
         end
      end
      return cnt;
   endfunction

   car_pkg::state_type      state_ff, state_in;
   logic [CNT_W-1:0]        want_ff, want_in;
   logic [SEL_W-1:0]        sel_ff, sel_in;
   logic                    first_ff, first_in;
   logic [CNT_W-1:0]        carry_ff, carry_in;
   logic [ADDR_W-1:0]       ptr_ff, ptr_in;
   logic                    more_ff, more_in;
   logic                    pend_ff, pend_in;
   logic [ADDR_W-1:0]       pword_ff, pword_in;
   logic                    rvalid_ff, rvalid_in;
   logic [IDX_W-1:0]        mk_start_ff, mk_start_in;
   logic [IDX_W-1:0]        mk_end_ff, mk_end_in;
   car_pkg::status_type     res_status_ff, res_status_in;
   logic [SEL_W-1:0]        res_sel_ff, res_sel_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   car_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic [SEL_W-1:0]        rsp_sel_ff, rsp_sel_in;
   logic [WORDS-1:0]        wvalid_ff, wvalid_in;
   logic [ENTRY_W-1:0]      first_free_ff, first_free_in;

   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_waddr;
   logic [WORD_W-1:0]       ram_wdata;
   logic                    ram_re;
   logic [ADDR_W-1:0]       ram_raddr;
   logic [WORD_W-1:0]       ram_q;

   logic [WORD_W-1:0]       rdata;
   logic [WORD_W-1:0]       free_vec;
   logic [WORD_W-1:0]       win;
   logic [WORD_W-1:0]       pre;
   logic [CNT_W-1:0]        dneed;
   logic [WORD_W-1:0]       ge;
   logic [WORD_W-1:0]       hit;
   logic [IDX_W-1:0]        hit_end;
   logic [CNT_W-1:0]        start_sum;
   logic [IDX_W-1:0]        hit_start;
   logic [BIT_W-1:0]        mk_lo;
   logic [BIT_W-1:0]        mk_hi;
   logic [WORD_W-1:0]       mk_mask;
   logic [ADDR_W-1:0]       fword;
   logic [BIT_W-1:0]        fbit;
   logic                    free_oor;
   logic                    ff_oor;
   logic                    csr_wr;

   car_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORDS)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_q)
   );

   // never-written words read as all free
   assign rdata = ram_q & {WORD_W{rvalid_ff}};
   assign free_vec = ~rdata &
                     (first_ff ? (ONES << first_free_ff[BIT_W-1:0]) : ONES);
   assign win = window_free(free_vec, want_ff);
   assign pre = prefix_free(free_vec);
   assign dneed = want_ff - carry_ff;
   assign ge = (dneed > CNT_W'(WORD_W)) ? '0 : (ONES << (dneed - CNT_W'(1)));
   assign hit = win | (pre & ge);
   assign hit_end = {pword_ff, lowest_set(hit)};
   assign start_sum = CNT_W'(hit_end) + CNT_W'(1) - want_ff;
   assign hit_start = start_sum[IDX_W-1:0];

   assign mk_lo = (pword_ff == mk_start_ff[IDX_W-1:BIT_W]) ? mk_start_ff[BIT_W-1:0] : '0;
   assign mk_hi = (pword_ff == mk_end_ff[IDX_W-1:BIT_W]) ? mk_end_ff[BIT_W-1:0] : '1;
   assign mk_mask = (ONES << mk_lo) & (ONES >> (~mk_hi));

   assign fword = sel_ff[IDX_W+car_pkg::SEL_SHIFT-1:BIT_W+car_pkg::SEL_SHIFT];
   assign fbit = sel_ff[BIT_W+car_pkg::SEL_SHIFT-1:car_pkg::SEL_SHIFT];
   assign free_oor = (CNT_W'(req_selector_in[SEL_W-1:car_pkg::SEL_SHIFT]) >=
                      CNT_W'(car_pkg::TABLE_ENTRIES));
   assign ff_oor = (CNT_W'(first_free_ff) >= CNT_W'(car_pkg::TABLE_ENTRIES));

   assign csr_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign prdata = (paddr[car_pkg::CSR_ADDR_W-1] == car_pkg::CSR_REG_FIRST_FREE) ?
                   car_pkg::CSR_DATA_W'(first_free_ff) : '0;

   assign req_ready = (state_ff == car_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_selector_out = rsp_sel_ff;

   always_comb begin
      state_in = state_ff;
      want_in = want_ff;
      sel_in = sel_ff;
      first_in = first_ff;
      carry_in = carry_ff;
      ptr_in = ptr_ff;
      more_in = more_ff;
      pend_in = pend_ff;
      pword_in = pword_ff;
      mk_start_in = mk_start_ff;
      mk_end_in = mk_end_ff;
      res_status_in = res_status_ff;
      res_sel_in = res_sel_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_sel_in = rsp_sel_ff;
      first_free_in = first_free_ff;
      ram_we = 1'b0;
      ram_waddr = pword_ff;
      ram_wdata = rdata | mk_mask;
      ram_re = 1'b0;
      ram_raddr = ptr_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_wr && paddr[car_pkg::CSR_ADDR_W-1] == car_pkg::CSR_REG_FIRST_FREE) begin
         first_free_in = pwdata[ENTRY_W-1:0];
      end

      case (state_ff)
         car_pkg::ST_IDLE: begin
            if (req_valid) begin
               want_in = req_run_length;
               sel_in = req_selector_in;
               if (req_opcode == car_pkg::OP_FREE) begin
                  if (free_oor) begin
                     res_status_in = car_pkg::STATUS_WAS_FREE;
                     res_sel_in = req_selector_in;
                     state_in = car_pkg::ST_DONE;
                  end else begin
                     state_in = car_pkg::ST_FRD;
                  end
               end else if (req_run_length == '0 || ff_oor) begin
                  res_status_in = car_pkg::STATUS_NO_ROOM;
                  res_sel_in = '0;
                  state_in = car_pkg::ST_DONE;
               end else begin
                  ptr_in = first_free_ff[IDX_W-1:BIT_W];
                  more_in = 1'b1;
                  pend_in = 1'b0;
                  carry_in = '0;
                  first_in = 1'b1;
                  state_in = car_pkg::ST_SCAN;
               end
            end
         end
         car_pkg::ST_SCAN: begin
            ram_re = more_ff;
            pend_in = more_ff;
            pword_in = ptr_ff;
            if (more_ff) begin
               if (ptr_ff == LAST_WORD) begin
                  more_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + ADDR_W'(1);
               end
            end
            if (pend_ff) begin
               first_in = 1'b0;
               if (hit != '0) begin
                  mk_start_in = hit_start;
                  mk_end_in = hit_end;
                  ptr_in = hit_start[IDX_W-1:BIT_W];
                  more_in = 1'b1;
                  pend_in = 1'b0;
                  state_in = car_pkg::ST_MARK;
               end else begin
                  carry_in = pre[WORD_W-1] ? carry_ff + CNT_W'(WORD_W) :
                                             CNT_W'(top_free(free_vec));
                  if (pword_ff == LAST_WORD) begin
                     res_status_in = car_pkg::STATUS_NO_ROOM;
                     res_sel_in = '0;
                     state_in = car_pkg::ST_DONE;
                  end
               end
            end
         end
         car_pkg::ST_MARK: begin
            ram_re = more_ff;
            pend_in = more_ff;
            pword_in = ptr_ff;
            if (more_ff) begin
               if (ptr_ff == mk_end_ff[IDX_W-1:BIT_W]) begin
                  more_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + ADDR_W'(1);
               end
            end
            if (pend_ff) begin
               ram_we = 1'b1;
               if (pword_ff == mk_end_ff[IDX_W-1:BIT_W]) begin
                  res_status_in = car_pkg::STATUS_OK;
                  res_sel_in = SEL_W'({mk_start_ff, car_pkg::SEL_LOW_BITS});
                  state_in = car_pkg::ST_DONE;
               end
            end
         end
         car_pkg::ST_FRD: begin
            ram_re = 1'b1;
            ram_raddr = fword;
            state_in = car_pkg::ST_FCHK;
         end
         car_pkg::ST_FCHK: begin
            ram_waddr = fword;
            ram_wdata = rdata & ~(WORD_W'(1) << fbit);
            if (rdata[fbit]) begin
               ram_we = 1'b1;
               res_status_in = car_pkg::STATUS_OK;
               res_sel_in = '0;
            end else begin
               res_status_in = car_pkg::STATUS_WAS_FREE;
               res_sel_in = sel_ff;
            end
            state_in = car_pkg::ST_DONE;
         end
         car_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_sel_in = res_sel_ff;
               state_in = car_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = car_pkg::ST_IDLE;
         end
      endcase

      rvalid_in = ram_re ? wvalid_ff[ram_raddr] : rvalid_ff;
      wvalid_in = wvalid_ff;
      if (ram_we) begin
         wvalid_in[ram_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= car_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wvalid_ff <= '0;
         first_free_ff <= car_pkg::FIRST_FREE_RESET;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wvalid_ff <= wvalid_in;
         first_free_ff <= first_free_in;
      end
   end

   always_ff @(posedge clock) begin
      want_ff <= want_in;
      sel_ff <= sel_in;
      first_ff <= first_in;
      carry_ff <= carry_in;
      ptr_ff <= ptr_in;
      more_ff <= more_in;
      pend_ff <= pend_in;
      pword_ff <= pword_in;
      rvalid_ff <= rvalid_in;
      mk_start_ff <= mk_start_in;
      mk_end_ff <= mk_end_in;
      res_status_ff <= res_status_in;
      res_sel_ff <= res_sel_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sel_ff <= rsp_sel_in;
   end

`ifndef NO_ASSERTIONS
   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == car_pkg::ST_SCAN) |-> !ram_we)
      else $error("map written during scan");

   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == car_pkg::ST_MARK && ram_we) |->
      (pword_ff >= mk_start_ff[IDX_W-1:BIT_W] && pword_ff <= mk_end_ff[IDX_W-1:BIT_W]))
      else $error("mark write outside run");

   a_run_above_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == car_pkg::ST_MARK) |-> (ENTRY_W'(mk_start_ff) >= first_free_ff))
      else $error("run starts below first free entry");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == car_pkg::ST_DONE && (!rsp_valid_ff || rsp_ready)) |=>
      (rsp_valid_ff && state_ff == car_pkg::ST_IDLE))
      else $error("result not queued");
`endif

endmodule
